[rtl/ordered_fragment_reassembler_unit_macros.svh]
// ============================================================================
// Assertion macros for the ordered fragment reassembler
// Shared property shorthands. Each one samples on clk and is disabled in rst.
// ============================================================================
`ifndef ORDERED_FRAGMENT_REASSEMBLER_UNIT_MACROS_SVH
`define ORDERED_FRAGMENT_REASSEMBLER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OFR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ofr_pkg.sv]
// ============================================================================
// ofr_pkg
// Shared constants, codes and structs of the ordered fragment reassembler.
// ============================================================================
`timescale 1ns / 1ps

package ofr_pkg;

  // Reassembly buffer size and derived widths.
  localparam int BUF_BYTES = 4096;
  localparam int ADDR_W    = $clog2(BUF_BYTES);
  localparam int LEN_W     = 13;
  localparam int FIELD_W   = 17;
  localparam int MAG_W     = FIELD_W - 1;
  localparam int RADDR_W   = 12;
  localparam logic [LEN_W-1:0] CAP_RESET = LEN_W'(4096);
  localparam logic [LEN_W-1:0] BUF_LIMIT = LEN_W'(BUF_BYTES);

  // Item kinds carried in the input tuser.
  typedef enum logic [1:0] {
    ACT_HEADER = 2'd0,
    ACT_DATA   = 2'd1,
    ACT_READ   = 2'd2,
    ACT_UNUSED = 2'd3
  } action_t;

  // Result status codes.
  typedef enum logic [3:0] {
    ST_AWAIT         = 4'd0,
    ST_STORED        = 4'd1,
    ST_INCOMPLETE    = 4'd2,
    ST_COMPLETE      = 4'd3,
    ST_READ_OK       = 4'd4,
    ST_NEGATIVE      = 4'd5,
    ST_OVER_CAP      = 4'd6,
    ST_FIRST_LARGE   = 4'd7,
    ST_NO_MESSAGE    = 4'd8,
    ST_TOTAL_CHANGED = 4'd9,
    ST_BAD_OFFSET    = 4'd10,
    ST_OVERRUN       = 4'd11,
    ST_SEQUENCE      = 4'd12
  } status_t;

  // One input item, unpacked.
  typedef struct packed {
    action_t                    action;
    logic signed [FIELD_W-1:0]  total_len;
    logic signed [FIELD_W-1:0]  fragment_offset;
    logic signed [FIELD_W-1:0]  fragment_length;
    logic [7:0]                 data_byte;
    logic [RADDR_W-1:0]         read_address;
  } item_t;

  // Reassembly context of the message in progress.
  typedef struct packed {
    logic             active;
    logic [LEN_W-1:0] exp_total;
    logic [LEN_W-1:0] received;
    logic [LEN_W-1:0] wr_ptr;
    logic [LEN_W-1:0] frag_end;
    logic             expecting;
  } ctx_t;

  // Result of one item handed from the control to the output stage.
  typedef struct packed {
    status_t          status;
    logic             dropped;
    logic [LEN_W-1:0] message_length;
    logic             use_ram;
  } result_t;

endpackage

[rtl/ofr_ram.sv]
// ============================================================================
// ofr_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
`timescale 1ns / 1ps

module ofr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds between reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/ofr_ctrl.sv]
// ============================================================================
// ofr_ctrl
// Header checks, reassembly context, capacity register and buffer access.
// ============================================================================
`timescale 1ns / 1ps
`include "ordered_fragment_reassembler_unit_macros.svh"

module ofr_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  ofr_pkg::item_t             item,
  input  logic                       cfg_valid,
  input  logic [ofr_pkg::LEN_W-1:0]  cfg_data,
  output ofr_pkg::result_t           res,
  output logic                       ram_we,
  output logic [ofr_pkg::ADDR_W-1:0] ram_waddr,
  output logic [7:0]                 ram_wdata,
  output logic                       ram_re,
  output logic [ofr_pkg::ADDR_W-1:0] ram_raddr
);

  ofr_pkg::ctx_t                  state;
  ofr_pkg::ctx_t                  state_next;
  logic [ofr_pkg::LEN_W-1:0]      capacity;
  logic [ofr_pkg::LEN_W-1:0]      cap_eff;
  logic [ofr_pkg::MAG_W-1:0]      total;
  logic [ofr_pkg::MAG_W-1:0]      off;
  logic [ofr_pkg::MAG_W-1:0]      len;
  logic                           any_neg;
  logic [ofr_pkg::LEN_W-1:0]      remain;
  logic [ofr_pkg::LEN_W-1:0]      wr_inc;
  logic                           rd_hit;

  // Capacity above the buffer size acts as the buffer size.
  assign cap_eff = (capacity > ofr_pkg::BUF_LIMIT) ? ofr_pkg::BUF_LIMIT : capacity;

  // Header fields as magnitudes; the sign bits flag a corrupt header.
  assign total   = item.total_len[ofr_pkg::MAG_W-1:0];
  assign off     = item.fragment_offset[ofr_pkg::MAG_W-1:0];
  assign len     = item.fragment_length[ofr_pkg::MAG_W-1:0];
  assign any_neg = item.total_len[ofr_pkg::FIELD_W-1] |
                   item.fragment_offset[ofr_pkg::FIELD_W-1] |
                   item.fragment_length[ofr_pkg::FIELD_W-1];
  assign remain  = state.exp_total - state.received;
  assign wr_inc  = state.wr_ptr + ofr_pkg::LEN_W'(1);
  assign rd_hit  = ({1'b0, item.read_address} < (ofr_pkg::RADDR_W+1)'(ofr_pkg::BUF_BYTES));

  // Buffer port addressing.
  assign ram_waddr = state.wr_ptr[ofr_pkg::ADDR_W-1:0];
  assign ram_wdata = item.data_byte;
  assign ram_raddr = item.read_address[ofr_pkg::ADDR_W-1:0];

  // Decision logic for one item.
  always_comb begin
    state_next         = state;
    res.status         = ofr_pkg::ST_SEQUENCE;
    res.dropped        = 1'b0;
    res.message_length = '0;
    res.use_ram        = 1'b0;
    ram_we             = 1'b0;
    ram_re             = 1'b0;
    case (item.action)
      ofr_pkg::ACT_HEADER: begin
        if (any_neg) begin
          state_next = '0;
          res.status = ofr_pkg::ST_NEGATIVE;
        end else if (off == '0) begin
          // First fragment: any unfinished message is discarded.
          state_next = '0;
          if (total > ofr_pkg::MAG_W'(cap_eff)) begin
            res.status = ofr_pkg::ST_OVER_CAP;
          end else if (len > total) begin
            res.status = ofr_pkg::ST_FIRST_LARGE;
          end else begin
            res.dropped          = state.active;
            state_next.active    = 1'b1;
            state_next.exp_total = total[ofr_pkg::LEN_W-1:0];
            if (len != '0) begin
              state_next.frag_end  = len[ofr_pkg::LEN_W-1:0];
              state_next.expecting = 1'b1;
              res.status           = ofr_pkg::ST_AWAIT;
            end else if (total != '0) begin
              res.status = ofr_pkg::ST_INCOMPLETE;
            end else begin
              state_next = '0;
              res.status = ofr_pkg::ST_COMPLETE;
            end
          end
        end else if (state.expecting) begin
          state_next = '0;
          res.status = ofr_pkg::ST_SEQUENCE;
        end else if (!state.active) begin
          state_next = '0;
          res.status = ofr_pkg::ST_NO_MESSAGE;
        end else if (total != ofr_pkg::MAG_W'(state.exp_total)) begin
          state_next = '0;
          res.status = ofr_pkg::ST_TOTAL_CHANGED;
        end else if (off != ofr_pkg::MAG_W'(state.received)) begin
          state_next = '0;
          res.status = ofr_pkg::ST_BAD_OFFSET;
        end else if (len > ofr_pkg::MAG_W'(remain)) begin
          state_next = '0;
          res.status = ofr_pkg::ST_OVERRUN;
        end else if (len == '0) begin
          // Empty continuation ends the fragment at the current count.
          if (state.received < state.exp_total) begin
            res.status = ofr_pkg::ST_INCOMPLETE;
          end else begin
            state_next         = '0;
            res.status         = ofr_pkg::ST_COMPLETE;
            res.message_length = state.received;
          end
        end else begin
          state_next.wr_ptr    = off[ofr_pkg::LEN_W-1:0];
          state_next.frag_end  = off[ofr_pkg::LEN_W-1:0] + len[ofr_pkg::LEN_W-1:0];
          state_next.expecting = 1'b1;
          res.status           = ofr_pkg::ST_AWAIT;
        end
      end
      ofr_pkg::ACT_DATA: begin
        if (!state.expecting || state.wr_ptr >= state.frag_end ||
            state.wr_ptr >= ofr_pkg::BUF_LIMIT) begin
          state_next = '0;
          res.status = ofr_pkg::ST_SEQUENCE;
        end else begin
          ram_we            = accept;
          state_next.wr_ptr = wr_inc;
          if (wr_inc < state.frag_end) begin
            res.status = ofr_pkg::ST_STORED;
          end else if (state.frag_end < state.exp_total) begin
            state_next.received  = state.frag_end;
            state_next.expecting = 1'b0;
            res.status           = ofr_pkg::ST_INCOMPLETE;
          end else begin
            state_next         = '0;
            res.status         = ofr_pkg::ST_COMPLETE;
            res.message_length = state.frag_end;
          end
        end
      end
      ofr_pkg::ACT_READ: begin
        res.status  = ofr_pkg::ST_READ_OK;
        res.use_ram = rd_hit;
        ram_re      = accept & rd_hit;
      end
      default: begin
        res.status = ofr_pkg::ST_SEQUENCE;
      end
    endcase
  end

  // Context and capacity registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= '0;
      capacity <= ofr_pkg::CAP_RESET;
    end else begin
      if (accept) begin
        state <= state_next;
      end
      if (cfg_valid) begin
        capacity <= cfg_data;
      end
    end
  end

  // Context invariants.
  `OFR_ASSERT_IMPL(a_expect_active, state.expecting, state.active, "payload expected with no message")
  `OFR_ASSERT_IMPL(a_ptr_below_end, state.expecting, state.wr_ptr < state.frag_end, "write pointer past fragment end")
  `OFR_ASSERT_IMPL(a_end_in_total, state.active, state.frag_end <= state.exp_total, "fragment end beyond total")
  `OFR_ASSERT_IMPL(a_count_below_total, state.active, state.received < state.exp_total, "active message already complete")
  `OFR_ASSERT_NEXT(a_ptr_advance, accept && res.status == ofr_pkg::ST_STORED, state.wr_ptr == ofr_pkg::LEN_W'($past(state.wr_ptr) + ofr_pkg::LEN_W'(1)), "write pointer did not advance")

endmodule

[rtl/ofr_out.sv]
// ============================================================================
// ofr_out
// Output register: holds one result until the consumer takes it.
// ============================================================================
`timescale 1ns / 1ps

module ofr_out (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  ofr_pkg::result_t          res,
  input  logic [7:0]                ram_rdata,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic                      in_ready,
  output ofr_pkg::status_t          status,
  output logic                      dropped_previous,
  output logic [ofr_pkg::LEN_W-1:0] message_length,
  output logic [7:0]                read_data
);

  ofr_pkg::result_t held;

  // The stage takes a new result when empty or when its result leaves now.
  assign in_ready = !out_valid || out_ready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= accept;
    end
  end

  // Result payload; buffer read data joins from the registered RAM port.
  always_ff @(posedge clk) begin
    if (accept) begin
      held <= res;
    end
  end

  assign status           = held.status;
  assign dropped_previous = held.dropped;
  assign message_length   = held.message_length;
  assign read_data        = held.use_ram ? ram_rdata : 8'd0;

endmodule

[rtl/ordered_fragment_reassembler_unit.sv]
// ============================================================================
// ordered_fragment_reassembler_unit
// Rebuilds one message from in-order fragments into a byte buffer RAM.
// ============================================================================
//
//   Channel   Direction  Handshake          Contents
//   s_*       in         s_tvalid/s_tready  header, data byte or read request
//   m_*       out        m_tvalid/m_tready  status, drop flag, length, read byte
//   cfg_*     in         cfg_valid/cfg_ready capacity register write
//
// One item is accepted per cycle while s_tready is high; its result is presented the next cycle.
// Read data comes from the buffer RAM's registered port in that same cycle.
// s_tready is low only while a result waits in the output register unread.
// rst clears the reassembly context and sets capacity to 4096 bytes.
// The buffer RAM is not cleared; no clearing pass follows reset.
`timescale 1ns / 1ps

module ordered_fragment_reassembler_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // total_len[16:0], fragment_offset[33:17], fragment_length[50:34],
  // data_byte[58:51], read_address[70:59], zero[71]
  input  logic [71:0] s_tdata,
  // action[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // dropped_previous[0], message_length[13:1], read_data[21:14], zero[23:22]
  output logic [23:0] m_tdata,
  // status[3:0]
  output logic [3:0]  m_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data
);

  ofr_pkg::item_t                 item;
  ofr_pkg::result_t               res;
  logic                           accept;
  logic                           ram_we;
  logic                           ram_re;
  logic [ofr_pkg::ADDR_W-1:0]     ram_waddr;
  logic [ofr_pkg::ADDR_W-1:0]     ram_raddr;
  logic [7:0]                     ram_wdata;
  logic [7:0]                     ram_rdata;
  ofr_pkg::status_t               status;
  logic                           dropped_previous;
  logic [ofr_pkg::LEN_W-1:0]      message_length;
  logic [7:0]                     read_data;

  // Unpack the input transaction.
  assign item.action          = ofr_pkg::action_t'(s_tuser);
  assign item.total_len       = s_tdata[16:0];
  assign item.fragment_offset = s_tdata[33:17];
  assign item.fragment_length = s_tdata[50:34];
  assign item.data_byte       = s_tdata[58:51];
  assign item.read_address    = s_tdata[70:59];

  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  ofr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr)
  );

  ofr_ram #(
    .WIDTH (8),
    .DEPTH (ofr_pkg::BUF_BYTES)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ofr_out u_out (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .res              (res),
    .ram_rdata        (ram_rdata),
    .out_ready        (m_tready),
    .out_valid        (m_tvalid),
    .in_ready         (s_tready),
    .status           (status),
    .dropped_previous (dropped_previous),
    .message_length   (message_length),
    .read_data        (read_data)
  );

  // Pack the output transaction.
  assign m_tuser = status;
  assign m_tdata = {2'b00, read_data, message_length, dropped_previous};

endmodule
